// ===== rtl/lmpe_pkg.sv =====
package lmpe_pkg;

   // Build defaults.
   localparam int FLAKES_DEF      = 32;
   localparam int PANEL_COUNT_DEF = 2;

   // Fixed geometry of the field and of the position format.
   localparam int FIELD_W     = 12;
   localparam int PANEL_ROWS  = 8;
   localparam int PANEL_BYTES = 12;
   localparam int FRAC_BITS   = 8;
   localparam int XW          = 12;
   localparam int VW          = 8;

   // Widest pixel row and frame byte address over all supported panel counts.
   localparam int ROW_W     = 6;
   localparam int FB_ADDR_W = 7;

   // Operation codes.
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_SPAWN = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_SETPX = 3'd4;

   typedef struct packed {
      logic [2:0]        op;
      logic [3:0]        pos_x;
      logic [3:0]        pos_y;
      logic signed [7:0] vel_x;
      logic signed [7:0] vel_y;
      logic [4:0]        byte_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       accepted;
   } rsp_type;

   typedef struct packed {
      logic [FB_ADDR_W-1:0] byte_addr;
      logic [2:0]           bitpos;
   } pix_loc_type;

   // Control of the frame buffer: one registered read and one write per cycle.
   typedef struct packed {
      logic [FB_ADDR_W-1:0] rd_addr;
      logic                 wr_en;
      logic [FB_ADDR_W-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 clear;
   } fb_cmd_type;

   // Maps a pixel to its byte and bit in the panel wiring order.
   function automatic pix_loc_type pixel_loc(input logic [3:0] px,
                                             input logic [ROW_W-1:0] row);
      pix_loc_type loc;
      logic [2:0]  r;
      logic [2:0]  panel;
      logic [3:0]  lb;
      r     = row[2:0];
      panel = row[5:3];
      if (px < 4'd8) begin
         lb         = {1'b0, r ^ 3'd1};
         loc.bitpos = px[2:0];
      end else begin
         lb         = 4'd8 + {2'b00, r[2:1] ^ 2'd1};
         loc.bitpos = {r[0], px[1:0]};
      end
      loc.byte_addr = FB_ADDR_W'(lb) + {1'b0, panel, 3'b000} + {2'b00, panel, 2'b00};
      return loc;
   endfunction

endpackage

// ===== rtl/lmpe_frame_store.sv =====
module lmpe_frame_store #(
   parameter int BYTES = lmpe_pkg::PANEL_COUNT_DEF * lmpe_pkg::PANEL_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lmpe_pkg::fb_cmd_type   cmd,
   output logic [7:0]             rd_data
);

   localparam int BA = $clog2(BYTES);

   logic [7:0]       mem [BYTES];
   logic [BYTES-1:0] valid_ff;
   logic [BYTES-1:0] valid_in;
   logic [7:0]       rd_data_ff;
   logic             rd_hit;
   logic             wr_hit;

   assign rd_hit = cmd.rd_addr < lmpe_pkg::FB_ADDR_W'(BYTES);
   assign wr_hit = cmd.wr_addr < lmpe_pkg::FB_ADDR_W'(BYTES);

   // A byte that was not written since reset or the last clear reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr_en && wr_hit) begin
         valid_in[cmd.wr_addr[BA-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_hit) begin
         mem[cmd.wr_addr[BA-1:0]] <= cmd.wr_data;
      end
      if (rd_hit && valid_ff[cmd.rd_addr[BA-1:0]]) begin
         rd_data_ff <= mem[cmd.rd_addr[BA-1:0]];
      end else begin
         rd_data_ff <= 8'd0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/led_matrix_particle_engine.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   lmpe_pkg::req_type (op, position, velocity, byte)
// rsp_      out        rsp_valid/rsp_ready   lmpe_pkg::rsp_type (read_data, accepted)
//
// One transaction is worked at a time; req_ready is high only while the sequencer is idle.
// Tick: a scan over all particle slots (dead particles are only passed over, live ones
// take a read-modify-write of the frame buffer and the shared adder). Spawn is a linear
// scan for a free slot. Synchronous reset kills all particles and empties the frame at once.
// A stalled rsp_ holds the finished result and keeps the sequencer from going idle.
module led_matrix_particle_engine #(
   parameter int FLAKES      = lmpe_pkg::FLAKES_DEF,
   parameter int PANEL_COUNT = lmpe_pkg::PANEL_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lmpe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lmpe_pkg::rsp_type rsp_data
);

   localparam int IW          = (FLAKES > 1) ? $clog2(FLAKES) : 1;
   localparam int FRAC        = lmpe_pkg::FRAC_BITS;
   localparam int FRAME_BYTES = PANEL_COUNT * lmpe_pkg::PANEL_BYTES;
   localparam int FIELD_H     = PANEL_COUNT * lmpe_pkg::PANEL_ROWS;
   localparam int XW          = lmpe_pkg::XW;
   localparam int VW          = lmpe_pkg::VW;
   localparam int YW          = $clog2(FIELD_H << FRAC);
   localparam int AW          = ((YW > XW) ? YW : XW) + 1;
   localparam int FW          = XW + YW + 2 * VW;
   localparam int X_LIM       = lmpe_pkg::FIELD_W << FRAC;
   localparam int Y_LIM       = FIELD_H << FRAC;
   localparam int RW          = lmpe_pkg::ROW_W;
   localparam int FAW         = lmpe_pkg::FB_ADDR_W;

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_TK_SCAN = 13'b0000000000010,
      S_TK_LOAD = 13'b0000000000100,
      S_TK_CLR  = 13'b0000000001000,
      S_TK_MVY  = 13'b0000000010000,
      S_TK_WB   = 13'b0000000100000,
      S_TK_SET  = 13'b0000001000000,
      S_SP_SCAN = 13'b0000010000000,
      S_SPX_RD  = 13'b0000100000000,
      S_SPX_WR  = 13'b0001000000000,
      S_RD_ISS  = 13'b0010000000000,
      S_RD_DATA = 13'b0100000000000,
      S_DONE    = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   lmpe_pkg::req_type    req_ff, req_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [FLAKES-1:0]    alive_ff, alive_in;
   logic [XW-1:0]        wx_ff, wx_in;
   logic [YW-1:0]        wy_ff, wy_in;
   logic [FAW-1:0]       pa_ff, pa_in;
   logic [2:0]           pb_ff, pb_in;
   logic [7:0]           res_rd_ff, res_rd_in;
   logic                 res_acc_ff, res_acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lmpe_pkg::rsp_type    rsp_ff, rsp_in;

   logic [FW-1:0]        flake_mem [FLAKES];
   logic [FW-1:0]        flake_rd_ff;
   logic                 flake_we;
   logic [FW-1:0]        flake_wdata;
   logic [XW-1:0]        f_x;
   logic [YW-1:0]        f_y;
   logic [VW-1:0]        f_dx;
   logic [VW-1:0]        f_dy;

   lmpe_pkg::fb_cmd_type fcmd;
   logic [7:0]           frame_rd;

   logic [3:0]           pm_px;
   logic [RW-1:0]        pm_row;
   lmpe_pkg::pix_loc_type pm_loc;

   logic [AW-1:0]        add_a, add_b, add_sum, add_lim;
   logic                 add_out;
   logic                 last_idx;

   assign f_x  = flake_rd_ff[FW-1 -: XW];
   assign f_y  = flake_rd_ff[2*VW+YW-1 -: YW];
   assign f_dx = flake_rd_ff[2*VW-1 -: VW];
   assign f_dy = flake_rd_ff[VW-1:0];

   assign last_idx  = idx_ff == IW'(FLAKES - 1);
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Pixel mapper, shared by the old and new particle positions and by set pixel.
   always_comb begin
      case (state_ff)
         S_TK_LOAD: begin
            pm_px  = f_x[XW-1 -: 4];
            pm_row = RW'(f_y[YW-1:FRAC]);
         end
         S_TK_WB: begin
            pm_px  = wx_ff[XW-1 -: 4];
            pm_row = RW'(wy_ff[YW-1:FRAC]);
         end
         default: begin
            pm_px  = req_ff.pos_x;
            pm_row = RW'(req_ff.pos_y);
         end
      endcase
   end

   assign pm_loc = lmpe_pkg::pixel_loc(pm_px, pm_row);

   // Shared adder: x step in the clear state, y step in the next one.
   always_comb begin
      if (state_ff == S_TK_MVY) begin
         add_a   = AW'(f_y);
         add_b   = {{(AW-VW){f_dy[VW-1]}}, f_dy};
         add_lim = AW'(Y_LIM);
      end else begin
         add_a   = AW'(f_x);
         add_b   = {{(AW-VW){f_dx[VW-1]}}, f_dx};
         add_lim = AW'(X_LIM);
      end
   end

   assign add_sum = add_a + add_b;
   assign add_out = add_sum[AW-1] || (add_sum >= add_lim);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      alive_in     = alive_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      res_rd_in    = res_rd_ff;
      res_acc_in   = res_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      flake_we     = 1'b0;
      flake_wdata  = {wx_ff, wy_ff, f_dx, f_dy};
      fcmd.rd_addr = pm_loc.byte_addr;
      fcmd.wr_en   = 1'b0;
      fcmd.wr_addr = pa_ff;
      fcmd.wr_data = frame_rd | (8'd1 << pb_ff);
      fcmd.clear   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               idx_in     = '0;
               res_rd_in  = 8'd0;
               res_acc_in = 1'b0;
               case (req_data.op)
                  lmpe_pkg::OP_TICK: begin
                     state_in = S_TK_SCAN;
                  end
                  lmpe_pkg::OP_SPAWN: begin
                     state_in = (req_data.pos_x < 4'(lmpe_pkg::FIELD_W)) ? S_SP_SCAN : S_DONE;
                  end
                  lmpe_pkg::OP_CLEAR: begin
                     alive_in   = '0;
                     fcmd.clear = 1'b1;
                     state_in   = S_DONE;
                  end
                  lmpe_pkg::OP_READ: begin
                     state_in = (FAW'(req_data.byte_index) < FAW'(FRAME_BYTES)) ?
                                S_RD_ISS : S_DONE;
                  end
                  lmpe_pkg::OP_SETPX: begin
                     state_in = ((req_data.pos_x < 4'(lmpe_pkg::FIELD_W)) &&
                                 (FAW'(req_data.pos_y) < FAW'(FIELD_H))) ? S_SPX_RD : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_TK_SCAN: begin
            if (alive_ff[idx_ff]) begin
               state_in = S_TK_LOAD;
            end else if (last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TK_LOAD: begin
            pa_in    = pm_loc.byte_addr;
            pb_in    = pm_loc.bitpos;
            state_in = S_TK_CLR;
         end
         S_TK_CLR: begin
            fcmd.wr_en   = 1'b1;
            fcmd.wr_data = frame_rd & ~(8'd1 << pb_ff);
            if (add_out) begin
               alive_in[idx_ff] = 1'b0;
               if (last_idx) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TK_SCAN;
               end
            end else begin
               wx_in    = add_sum[XW-1:0];
               state_in = S_TK_MVY;
            end
         end
         S_TK_MVY: begin
            if (add_out) begin
               alive_in[idx_ff] = 1'b0;
               if (last_idx) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TK_SCAN;
               end
            end else begin
               wy_in    = add_sum[YW-1:0];
               state_in = S_TK_WB;
            end
         end
         S_TK_WB: begin
            flake_we = 1'b1;
            pa_in    = pm_loc.byte_addr;
            pb_in    = pm_loc.bitpos;
            state_in = S_TK_SET;
         end
         S_TK_SET: begin
            fcmd.wr_en = 1'b1;
            if (last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TK_SCAN;
            end
         end
         S_SP_SCAN: begin
            if (!alive_ff[idx_ff]) begin
               flake_we         = 1'b1;
               flake_wdata      = {req_ff.pos_x, {FRAC{1'b0}}, {YW{1'b0}},
                                   req_ff.vel_x, req_ff.vel_y};
               alive_in[idx_ff] = 1'b1;
               res_acc_in       = 1'b1;
               state_in         = S_DONE;
            end else if (last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SPX_RD: begin
            pa_in    = pm_loc.byte_addr;
            pb_in    = pm_loc.bitpos;
            state_in = S_SPX_WR;
         end
         S_SPX_WR: begin
            fcmd.wr_en = 1'b1;
            res_acc_in = 1'b1;
            state_in   = S_DONE;
         end
         S_RD_ISS: begin
            fcmd.rd_addr = FAW'(req_ff.byte_index);
            state_in     = S_RD_DATA;
         end
         S_RD_DATA: begin
            res_rd_in = frame_rd;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.read_data = res_rd_ff;
               rsp_in.accepted  = res_acc_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alive_ff     <= alive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      wx_ff      <= wx_in;
      wy_ff      <= wy_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      res_rd_ff  <= res_rd_in;
      res_acc_ff <= res_acc_in;
      rsp_ff     <= rsp_in;
   end

   // Particle table: one port, read and written at the current particle.
   always_ff @(posedge clock) begin
      if (flake_we) begin
         flake_mem[idx_ff] <= flake_wdata;
      end
      flake_rd_ff <= flake_mem[idx_ff];
   end

   lmpe_frame_store #(
      .BYTES (FRAME_BYTES)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fcmd),
      .rd_data (frame_rd)
   );

`ifndef NO_ASSERTIONS
   a_clear_kills_all: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_data.op == lmpe_pkg::OP_CLEAR)
      |=> alive_ff == '0)
      else $error("clear all left a particle alive");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !fcmd.wr_en)
      else $error("frame buffer written while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the completion state");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.read_data != 8'd0))
      else $error("response carries both read data and an accept flag");
`endif

endmodule

// ===== test/led_matrix_particle_engine_test.sv =====
module led_matrix_particle_engine_test;

   localparam int FLAKES      = lmpe_pkg::FLAKES_DEF;
   localparam int PANELS      = lmpe_pkg::PANEL_COUNT_DEF;
   localparam int FIELD_W     = lmpe_pkg::FIELD_W;
   localparam int FRAC_BITS   = lmpe_pkg::FRAC_BITS;
   localparam int PANEL_ROWS  = lmpe_pkg::PANEL_ROWS;
   localparam int PANEL_BYTES = lmpe_pkg::PANEL_BYTES;
   localparam int ROWS        = PANELS * PANEL_ROWS;
   localparam int FRAME_BYTES = PANELS * PANEL_BYTES;
   localparam int STALL_LIMIT = 4000;
   localparam int REPORT_MAX  = 10;

   // Op codes the block treats as no-ops.
   localparam logic [2:0] OP_UNUSED5 = 3'd5;
   localparam logic [2:0] OP_UNUSED6 = 3'd6;
   localparam logic [2:0] OP_UNUSED7 = 3'd7;

   localparam bit PINNED = 1'b1;
   localparam bit MODELED = 1'b0;

   typedef struct {
      lmpe_pkg::req_type stim;
      int                reps;
      bit                pinned;
      lmpe_pkg::rsp_type want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   lmpe_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   lmpe_pkg::rsp_type rsp_data;

   // Shadow copy of the particle table and the frame buffer.
   int         flake_px [FLAKES];
   int         flake_py [FLAKES];
   int         flake_vx [FLAKES];
   int         flake_vy [FLAKES];
   bit         flake_live [FLAKES];
   logic [7:0] frame_img [FRAME_BYTES];

   lmpe_pkg::rsp_type pending_rsp[$];
   plan_row_type      plan[$];
   lmpe_pkg::rsp_type predicted;
   lmpe_pkg::rsp_type oldest;
   bit                pin_on;
   lmpe_pkg::rsp_type pin_rsp;
   bit                no_gaps;
   int                quiet_cycles;
   int                faults;
   int                checked;
   int                n_tick, n_spawn, n_spawned, n_read, n_setpx, n_clear, n_spare;

   led_matrix_particle_engine #(
      .FLAKES      (FLAKES),
      .PANEL_COUNT (PANELS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void paint(int col, int row, bit lit);
      int r;
      int byte_no;
      int bit_no;
      if (col < 0 || col >= FIELD_W || row < 0 || row >= ROWS) return;
      r = row % PANEL_ROWS;
      if (col < 8) begin
         byte_no = r ^ 1;
         bit_no  = col;
      end else begin
         byte_no = 8 + (((r >> 1) ^ 1) & 3);
         bit_no  = (col - 8) + 4 * (r & 1);
      end
      byte_no = byte_no + PANEL_BYTES * (row / PANEL_ROWS);
      frame_img[byte_no][bit_no] = lit;
   endfunction

   function automatic void move_flakes();
      for (int i = 0; i < FLAKES; i++) begin
         if (!flake_live[i]) continue;
         paint(flake_px[i] >>> FRAC_BITS, flake_py[i] >>> FRAC_BITS, 1'b0);
         flake_px[i] = flake_px[i] + flake_vx[i];
         if (flake_px[i] < 0 || flake_px[i] >= (FIELD_W << FRAC_BITS)) begin
            flake_live[i] = 1'b0;
            continue;
         end
         flake_py[i] = flake_py[i] + flake_vy[i];
         if (flake_py[i] < 0 || flake_py[i] >= (ROWS << FRAC_BITS)) begin
            flake_live[i] = 1'b0;
            continue;
         end
         paint(flake_px[i] >>> FRAC_BITS, flake_py[i] >>> FRAC_BITS, 1'b1);
      end
   endfunction

   function automatic lmpe_pkg::rsp_type predict_step(lmpe_pkg::req_type t);
      lmpe_pkg::rsp_type res;
      res = '0;
      case (t.op)
         lmpe_pkg::OP_TICK: move_flakes();
         lmpe_pkg::OP_SPAWN: begin
            if (t.pos_x < FIELD_W) begin
               for (int i = 0; i < FLAKES; i++) begin
                  if (!flake_live[i]) begin
                     flake_px[i]   = int'(t.pos_x) << FRAC_BITS;
                     flake_py[i]   = 0;
                     flake_vx[i]   = int'($signed(t.vel_x));
                     flake_vy[i]   = int'($signed(t.vel_y));
                     flake_live[i] = 1'b1;
                     res.accepted  = 1'b1;
                     break;
                  end
               end
            end
         end
         lmpe_pkg::OP_CLEAR: begin
            foreach (flake_live[i]) flake_live[i] = 1'b0;
            foreach (frame_img[i]) frame_img[i] = '0;
         end
         lmpe_pkg::OP_READ: begin
            if (t.byte_index < FRAME_BYTES) res.read_data = frame_img[t.byte_index];
         end
         lmpe_pkg::OP_SETPX: begin
            if (t.pos_x < FIELD_W && t.pos_y < ROWS) begin
               paint(int'(t.pos_x), int'(t.pos_y), 1'b1);
               res.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic plan_row_type step_row(logic [2:0] op, int x, int y, int vx, int vy,
                                             int bi, int reps, bit pinned, int rd, bit acc);
      plan_row_type row;
      row.stim.op         = op;
      row.stim.pos_x      = x[3:0];
      row.stim.pos_y      = y[3:0];
      row.stim.vel_x      = vx[7:0];
      row.stim.vel_y      = vy[7:0];
      row.stim.byte_index = bi[4:0];
      row.reps            = reps;
      row.pinned          = pinned;
      row.want.read_data  = rd[7:0];
      row.want.accepted   = acc;
      return row;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return lmpe_pkg::OP_TICK;
      else if (r < 58) return lmpe_pkg::OP_SPAWN;
      else if (r < 80) return lmpe_pkg::OP_READ;
      else if (r < 94) return lmpe_pkg::OP_SETPX;
      else if (r < 95) return lmpe_pkg::OP_CLEAR;
      else begin
         case ($urandom_range(0, 2))
            0: return OP_UNUSED5;
            1: return OP_UNUSED6;
            default: return OP_UNUSED7;
         endcase
      end
   endfunction

   function automatic lmpe_pkg::req_type random_req(logic [2:0] op);
      lmpe_pkg::req_type t;
      int                d;
      // Fields that the op ignores still carry random bits.
      t    = lmpe_pkg::req_type'($urandom);
      t.op = op;
      if ($urandom_range(0, 99) < 85) t.pos_x = 4'($urandom_range(0, FIELD_W - 1));
      else t.pos_x = 4'($urandom_range(FIELD_W, 15));
      if ($urandom_range(0, 99) < 85) t.byte_index = 5'($urandom_range(0, FRAME_BYTES - 1));
      else t.byte_index = 5'($urandom_range(FRAME_BYTES, 31));
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            t.vel_x = $urandom_range(0, 1) ? 8'h7f : 8'h80;
            t.vel_y = $urandom_range(0, 1) ? 8'h7f : 8'h80;
         end
         default: begin
            // Mostly falling particles with a little sideways drift.
            d       = $urandom_range(0, 40);
            t.vel_x = 8'(d - 20);
            t.vel_y = 8'($urandom_range(32, 127));
         end
      endcase
      return t;
   endfunction

   task automatic send_item(lmpe_pkg::req_type t, bit pinned, lmpe_pkg::rsp_type want);
      int gap;
      gap = no_gaps ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_on    = pinned;
      pin_rsp   = want;
      req_data  <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // Response side: random back-pressure, mostly short stalls with a few long ones.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 99) < 85) stall_left = $urandom_range(1, 3);
               else stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_step(req_data);
            pending_rsp.push_back(pin_on ? pin_rsp : predicted);
            case (req_data.op)
               lmpe_pkg::OP_TICK:  n_tick++;
               lmpe_pkg::OP_SPAWN: begin
                  n_spawn++;
                  if (predicted.accepted) n_spawned++;
               end
               lmpe_pkg::OP_CLEAR: n_clear++;
               lmpe_pkg::OP_READ:  n_read++;
               lmpe_pkg::OP_SETPX: n_setpx++;
               default:            n_spare++;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               faults++;
               if (faults <= REPORT_MAX)
                  $display("Unexpected response: read_data %02h accepted %0d",
                           rsp_data.read_data, rsp_data.accepted);
            end else begin
               oldest = pending_rsp.pop_front();
               checked++;
               if (rsp_data.read_data !== oldest.read_data ||
                   rsp_data.accepted !== oldest.accepted) begin
                  faults++;
                  if (faults <= REPORT_MAX)
                     $display({"Response %0d: read_data exp %02h got %02h,",
                               " accepted exp %0d got %0d"},
                              checked, oldest.read_data, rsp_data.read_data,
                              oldest.accepted, rsp_data.accepted);
               end
            end
         end
         quiet_cycles <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                         0 : quiet_cycles + 1;
      end
   end

   initial begin
      quiet_cycles = 0;
      @(negedge clock);
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles without a transaction.", STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [2:0] op;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      pin_on    = 1'b0;
      pin_rsp   = '0;
      no_gaps   = 1'b0;
      faults    = 0;
      checked   = 0;
      n_tick = 0; n_spawn = 0; n_spawned = 0; n_read = 0;
      n_setpx = 0; n_clear = 0; n_spare = 0;
      foreach (flake_live[i]) begin
         flake_px[i]   = 0;
         flake_py[i]   = 0;
         flake_vx[i]   = 0;
         flake_vy[i]   = 0;
         flake_live[i] = 1'b0;
      end
      foreach (frame_img[i]) frame_img[i] = '0;

      //                      op                   x   y    vx    vy  bi  n  check   rd    acc
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0, 23, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,  15, 15,   -1,   -1, 31, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(OP_UNUSED5,          3,  3,    5,    5,  3, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(OP_UNUSED6,          0,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(OP_UNUSED7,         15, 15,   -1,   -1, 31, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_SETPX,  0,  0,    0,    0,  0, 1, PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_SETPX, 11, 15,    0,    0,  0, 1, PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_SETPX, 12,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_SETPX, 15, 15,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0,  1, 1, PINNED, 8'h01, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0, 22, 1, PINNED, 8'h80, 0));
      plan.push_back(step_row(lmpe_pkg::OP_TICK,   0,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      // Spawns off the right edge are refused.
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN, 12,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN, 15,  0, -128, -128,  0, 1, PINNED, 8'h00, 0));
      // Fast movers that leave on the right, on the left and off the top.
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN, 11,  0,  127,  127,  0, 1, PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN,  0,  0, -128,  127,  0, 1, PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN,  5,  0,    0, -128,  0, 1, PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN,  3,  0,    1,  127,  0, 1, PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_TICK,   0,  0,    0,    0,  0, 3, MODELED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0,  0, 1, MODELED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0, 10, 1, MODELED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_CLEAR,  0,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0, 22, 1, PINNED, 8'h00, 0));
      // Fill every slot with a resting particle, then one spawn too many.
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN,  7,  0,    0,    0,  0, FLAKES,
                              PINNED, 8'h00, 1));
      plan.push_back(step_row(lmpe_pkg::OP_SPAWN,  7,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_TICK,   0,  0,    0,    0,  0, 2, MODELED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_READ,   0,  0,    0,    0,  1, 1, MODELED, 8'h00, 0));
      plan.push_back(step_row(lmpe_pkg::OP_CLEAR,  0,  0,    0,    0,  0, 1, PINNED, 8'h00, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         repeat (plan[i].reps) send_item(plan[i].stim, plan[i].pinned, plan[i].want);

      // Random scenes; some run with no idling on either side.
      for (int s = 0; s < 12; s++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 57; k++) begin
            op = pick_op();
            send_item(random_req(op), MODELED, '0);
         end
         if ($urandom_range(0, 9) < 3) send_item(random_req(lmpe_pkg::OP_CLEAR), MODELED, '0);
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d ticks, %0d spawns (%0d placed), %0d reads, %0d pixel sets,",
               n_tick, n_spawn, n_spawned, n_read, n_setpx);
      $display("%0d clears and %0d unused ops; %0d responses checked, %0d faults.",
               n_clear, n_spare, checked, faults);
      if (faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
